// File: src/spd_pkg.sv
// Shared constants, codes and types of the steering PD controller.
// Holds the microprogram table used by the sequencer; no dependencies.
package spd_pkg;

  localparam int SAMPLE_W  = 21;
  localparam int GAIN_W    = 16;
  localparam int WORD_W    = 32;
  localparam int SCALE_W   = 31;
  localparam int CFG_IDX_W = 4;
  localparam int STEP_W    = 5;

  localparam logic signed [WORD_W-1:0] POSITION_LIMIT  = 32'sd256000;
  localparam logic signed [WORD_W-1:0] POSITION_CENTER = 32'sd131072000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IIR_IN    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IIR_FB    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_STEP   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_OFFS   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_STEP  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_OFFS  = 4'd7;

  // Multiplier operand pair codes
  localparam logic [3:0] MUL_NONE  = 4'd0;
  localparam logic [3:0] MUL_KB_X  = 4'd1;
  localparam logic [3:0] MUL_KA_H0 = 4'd2;
  localparam logic [3:0] MUL_H0_KP = 4'd3;
  localparam logic [3:0] MUL_T_KD  = 4'd4;
  localparam logic [3:0] MUL_IS_T  = 4'd5;
  localparam logic [3:0] MUL_OS_T  = 4'd6;
  localparam logic [3:0] MUL_IS_A  = 4'd7;
  localparam logic [3:0] MUL_OS_A  = 4'd8;

  // ALU operation codes
  localparam logic [3:0] ALU_NOP    = 4'd0;
  localparam logic [3:0] ALU_LDQ7   = 4'd1;
  localparam logic [3:0] ALU_YSUB   = 4'd2;
  localparam logic [3:0] ALU_DSUB   = 4'd3;
  localparam logic [3:0] ALU_TRIPLE = 4'd4;
  localparam logic [3:0] ALU_ADDD   = 4'd5;
  localparam logic [3:0] ALU_PIDADD = 4'd6;
  localparam logic [3:0] ALU_SAT    = 4'd7;
  localparam logic [3:0] ALU_CENTRE = 4'd8;
  localparam logic [3:0] ALU_L_IN   = 4'd9;
  localparam logic [3:0] ALU_R_OUT  = 4'd10;
  localparam logic [3:0] ALU_L_OUT  = 4'd11;
  localparam logic [3:0] ALU_R_IN   = 4'd12;

  // Sequencer jump codes
  localparam logic [1:0] JMP_NEXT   = 2'd0;
  localparam logic [1:0] JMP_IF_POS = 2'd1;
  localparam logic [1:0] JMP_END    = 2'd2;

  localparam logic [STEP_W-1:0] LAST_STEP = 5'd16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SCALE_W-1:0]  scale_t;

  typedef struct packed {
    logic [3:0]        mul;
    logic [3:0]        alu;
    logic [1:0]        jmp;
    logic [STEP_W-1:0] target;
  } uword_t;

  // Microprogram: filter, PD term, saturation, then one of two wheel branches
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '{mul: MUL_NONE, alu: ALU_NOP, jmp: JMP_NEXT, target: '0};
    case (step)
      5'd0:  w.mul = MUL_KB_X;
      5'd1:  begin w.mul = MUL_KA_H0; w.alu = ALU_LDQ7; end
      5'd2:  w.alu = ALU_YSUB;
      5'd3:  begin w.mul = MUL_H0_KP; w.alu = ALU_DSUB; end
      5'd4:  w.alu = ALU_LDQ7;
      5'd5:  w.alu = ALU_TRIPLE;
      5'd6:  w.alu = ALU_ADDD;
      5'd7:  w.mul = MUL_T_KD;
      5'd8:  w.alu = ALU_PIDADD;
      5'd9:  w.alu = ALU_SAT;
      5'd10: begin w.alu = ALU_CENTRE; w.jmp = JMP_IF_POS; w.target = 5'd14; end
      5'd11: w.mul = MUL_IS_T;
      5'd12: begin w.mul = MUL_OS_A; w.alu = ALU_L_IN; end
      5'd13: begin w.alu = ALU_R_OUT; w.jmp = JMP_END; end
      5'd14: w.mul = MUL_OS_T;
      5'd15: begin w.mul = MUL_IS_A; w.alu = ALU_L_OUT; end
      5'd16: begin w.alu = ALU_R_IN; w.jmp = JMP_END; end
      default: w.jmp = JMP_END;
    endcase
    return w;
  endfunction

endpackage

// File: src/spd_in_if.sv
// Input channel of the steering PD controller: valid/ready plus one sample.
// Depends on spd_pkg for the sample type.
interface spd_in_if import spd_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t position_sample;

  modport source (output valid, output position_sample, input ready);
  modport sink   (input valid, input position_sample, output ready);
endinterface

// File: src/spd_out_if.sv
// Result channel of the steering PD controller: valid/ready plus two wheel scales.
// Depends on spd_pkg for the scale type.
interface spd_out_if import spd_pkg::*; ();
  logic   valid;
  logic   ready;
  scale_t left_scale;
  scale_t right_scale;

  modport source (output valid, output left_scale, output right_scale, input ready);
  modport sink   (input valid, input left_scale, input right_scale, output ready);
endinterface

// File: src/steering_pd_with_iir_prefilter.sv
// Steering controller: IIR prefilter, PD term and differential wheel scaling.
// Microcoded datapath around one shared 32x32 multiplier; uses spd_pkg,
// spd_in_if and spd_out_if.
//
// Usage:
//   in_chan  carries one Q7 line-position sample per transaction.
//   out_chan carries the Q15 left and right wheel scale factors, one
//            transaction for every sample taken.
//   cfg_we/cfg_index/cfg_data write the gain, step and offset registers;
//   indexes above seven are ignored. Write only while the block is idle.
// Timing:
//   A sample runs through a 14-step microprogram (eleven common steps and
//   three for the chosen turning side), one step per cycle unless the last
//   step is held by a full output register, all sharing the single
//   registered multiplier. A new sample is taken only once the sequencer
//   has finished the previous one.
// Reset:
//   rst_n clears the configuration registers, the sample pair and the
//   filter history, and leaves both channels empty.
// Stalls:
//   The result sits in an output register; the next sample may be taken and
//   worked on while it waits. If the receiver still holds off when the next
//   result is ready, the sequencer holds on its last step.
module steering_pd_with_iir_prefilter
  import spd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  spd_in_if.sink                in_chan,
  spd_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [WORD_W-1:0]     cfg_data
);

  // Configuration registers
  logic signed [GAIN_W-1:0] kb_r, ka_r;
  logic [GAIN_W-1:0]        kp_r, kd_r;
  logic signed [WORD_W-1:0] istep_r, ioff_r, ostep_r, ooff_r;

  // Filter state
  sample_t                  prev_r, cur_r;
  logic signed [WORD_W-1:0] h0_r, h1_r, h2_r, h3_r;

  // Datapath registers
  logic signed [WORD_W-1:0]   a_r, t_r, l_r;
  logic signed [2*WORD_W-1:0] prod_r;
  logic                       neg_r;

  // Sequencer and output
  logic              busy_r, busy_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  scale_t            out_left_r, out_right_r;

  uword_t                     uw;
  logic                       in_acc, out_free, fire, finish;
  logic signed [WORD_W-1:0]   q7, q16, xsum, mul_a, mul_b;
  logic signed [WORD_W-1:0]   a_nxt, t_nxt, l_nxt, y_val, sat_val, p_shift, wheel, wheel_cl;
  logic signed [WORD_W-1:0]   right_val;

  assign uw       = ucode(step_r);
  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign fire     = busy_r && ((uw.jmp != JMP_END) || out_free);
  assign finish   = fire && (uw.jmp == JMP_END);

  assign in_chan.ready       = !busy_r;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.left_scale = out_left_r;
  assign out_chan.right_scale = out_right_r;

  assign q7   = $signed(prod_r[WORD_W+6:7]);
  assign q16  = $signed(prod_r[WORD_W+15:16]);
  assign xsum = WORD_W'(prev_r) + WORD_W'(cur_r);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kb_r <= '0; ka_r <= '0; kp_r <= '0; kd_r <= '0;
      istep_r <= '0; ioff_r <= '0; ostep_r <= '0; ooff_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IIR_IN:   kb_r    <= cfg_data[GAIN_W-1:0];
        CFG_IIR_FB:   ka_r    <= cfg_data[GAIN_W-1:0];
        CFG_PROP:     kp_r    <= cfg_data[GAIN_W-1:0];
        CFG_DERIV:    kd_r    <= cfg_data[GAIN_W-1:0];
        CFG_IN_STEP:  istep_r <= cfg_data;
        CFG_IN_OFFS:  ioff_r  <= cfg_data;
        CFG_OUT_STEP: ostep_r <= cfg_data;
        CFG_OUT_OFFS: ooff_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Select multiplier operands from the control word
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (uw.mul)
      MUL_KB_X:  begin mul_a = WORD_W'(kb_r); mul_b = xsum; end
      MUL_KA_H0: begin mul_a = WORD_W'(ka_r); mul_b = h0_r; end
      MUL_H0_KP: begin mul_a = h0_r; mul_b = $signed({{(WORD_W-GAIN_W){1'b0}}, kp_r}); end
      MUL_T_KD:  begin mul_a = t_r;  mul_b = $signed({{(WORD_W-GAIN_W){1'b0}}, kd_r}); end
      MUL_IS_T:  begin mul_a = istep_r; mul_b = t_r; end
      MUL_OS_T:  begin mul_a = ostep_r; mul_b = t_r; end
      MUL_IS_A:  begin mul_a = istep_r; mul_b = a_r; end
      MUL_OS_A:  begin mul_a = ostep_r; mul_b = a_r; end
      default: ;
    endcase
  end

  // ALU: one operation per step
  always_comb begin
    a_nxt     = a_r;
    t_nxt     = t_r;
    l_nxt     = l_r;
    y_val     = a_r - q7;
    sat_val   = (a_r > POSITION_LIMIT) ? POSITION_LIMIT :
                (a_r < -POSITION_LIMIT) ? -POSITION_LIMIT : a_r;
    p_shift   = {a_r[WORD_W-10:0], 9'b0};
    wheel     = q16 + (((uw.alu == ALU_L_IN) || (uw.alu == ALU_R_IN)) ? ioff_r : ooff_r);
    wheel_cl  = wheel[WORD_W-1] ? '0 : wheel;
    right_val = (uw.alu == ALU_R_IN) ? wheel_cl : wheel;
    case (uw.alu)
      ALU_LDQ7:   a_nxt = q7;
      ALU_DSUB:   t_nxt = h1_r - h2_r;
      ALU_TRIPLE: t_nxt = t_r + {t_r[WORD_W-2:0], 1'b0};
      ALU_ADDD:   t_nxt = t_r + h0_r - h3_r;
      ALU_PIDADD: a_nxt = a_r + q7;
      ALU_SAT:    a_nxt = sat_val;
      ALU_CENTRE: begin
        t_nxt = POSITION_CENTER + p_shift;
        a_nxt = POSITION_CENTER - p_shift;
      end
      ALU_L_IN:   l_nxt = wheel_cl;
      ALU_L_OUT:  l_nxt = wheel;
      default: ;
    endcase
  end

  // Datapath registers advance only on a firing step
  always_ff @(posedge clk) begin
    if (fire) begin
      a_r <= a_nxt;
      t_r <= t_nxt;
      l_r <= l_nxt;
      if (uw.mul != MUL_NONE) begin
        prod_r <= (2*WORD_W)'(mul_a) * (2*WORD_W)'(mul_b);
      end
      if (uw.alu == ALU_SAT) begin
        neg_r <= sat_val[WORD_W-1];
      end
    end
  end

  // Filter state: take the sample on acceptance, shift history on the update step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0; cur_r <= '0;
      h0_r <= '0; h1_r <= '0; h2_r <= '0; h3_r <= '0;
    end else begin
      if (in_acc) begin
        prev_r <= cur_r;
        cur_r  <= in_chan.position_sample;
      end
      if (fire && (uw.alu == ALU_YSUB)) begin
        h3_r <= h2_r;
        h2_r <= h1_r;
        h1_r <= h0_r;
        h0_r <= y_val;
      end
    end
  end

  // Step counter with conditional jump
  always_comb begin
    busy_nxt      = busy_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    if (in_acc) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (fire) begin
      case (uw.jmp)
        JMP_IF_POS: step_nxt = neg_r ? step_r + 1'b1 : uw.target;
        JMP_END: begin
          busy_nxt      = 1'b0;
          out_valid_nxt = 1'b1;
        end
        default:    step_nxt = step_r + 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the result register; Q16 to Q15 drops the low bit
  always_ff @(posedge clk) begin
    if (finish) begin
      out_left_r  <= l_r[WORD_W-1:1];
      out_right_r <= right_val[WORD_W-1:1];
    end
  end

  // Checks
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> busy_r && (step_r == '0))
    else $error("sequencer did not start at step zero");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (step_r <= LAST_STEP))
    else $error("step counter ran past the program");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && (uw.alu == ALU_SAT)) |=> ((a_r <= POSITION_LIMIT) && (a_r >= -POSITION_LIMIT)))
    else $error("PD output outside position limit");

  a_inner_left: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (uw.alu == ALU_L_IN)) |=> !l_r[WORD_W-1])
    else $error("inner left wheel negative");

  a_inner_right: assert property (@(posedge clk) disable iff (!rst_n)
    (finish && (uw.alu == ALU_R_IN)) |=> !out_right_r[SCALE_W-1])
    else $error("inner right wheel negative");

endmodule
